@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ rtl/qrsr_pkg.sv @@
package qrsr_pkg;

   // field widths
   localparam int QUAT_W     = 16;
   localparam int SCALE_W    = 24;
   localparam int COORD_W    = 24;
   localparam int ERR_OUT_W  = 32;
   localparam int PIDX_W     = 10;

   // set length limit
   localparam int MAX_POINTS = 1024;
   localparam int CNT_W      = $clog2(MAX_POINTS);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_QUAT_W = 3'd0,
      CSR_QUAT_X = 3'd1,
      CSR_QUAT_Y = 3'd2,
      CSR_QUAT_Z = 3'd3,
      CSR_SCALE  = 3'd4
   } csr_index_type;

   // datapath widths
   localparam int MUL_A_W    = 35;
   localparam int MUL_B_W    = 33;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int QPROD_W    = 32;
   localparam int RM_W       = 34;
   localparam int ACC_W      = 60;
   localparam int ROT_SHIFT  = 30;
   localparam int ROT_W      = ACC_W - ROT_SHIFT;
   localparam int SCL_P_W    = 56;
   localparam int SCL_SHIFT  = 16;
   localparam int SC_W       = SCL_P_W - SCL_SHIFT;
   localparam int ERR_W      = 41;
   localparam int SUM_W      = 64;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = SUM_W;
   localparam int NUM_QPROD  = 10;
   localparam int STEP_W     = 6;

endpackage

@@ rtl/qrsr_if.sv @@
// point-pair request channel
interface qrsr_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [qrsr_pkg::COORD_W-1:0]      ref_x;
   logic signed [qrsr_pkg::COORD_W-1:0]      ref_y;
   logic signed [qrsr_pkg::COORD_W-1:0]      ref_z;
   logic signed [qrsr_pkg::COORD_W-1:0]      tgt_x;
   logic signed [qrsr_pkg::COORD_W-1:0]      tgt_y;
   logic signed [qrsr_pkg::COORD_W-1:0]      tgt_z;
   logic                                     last_point;

   modport source (output valid, ref_x, ref_y, ref_z, tgt_x, tgt_y, tgt_z, last_point,
                   input ready);
   modport sink (input valid, ref_x, ref_y, ref_z, tgt_x, tgt_y, tgt_z, last_point,
                 output ready);
endinterface

// per-point result channel
interface qrsr_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [qrsr_pkg::ERR_OUT_W-1:0]           point_error;
   logic [qrsr_pkg::PIDX_W-1:0]              point_index;
   logic                                     set_done;
   logic [qrsr_pkg::ERR_OUT_W-1:0]           set_rmsd;
   logic                                     saturated;

   modport source (output valid, point_error, point_index, set_done, set_rmsd, saturated,
                   input ready);
   modport sink (input valid, point_error, point_index, set_done, set_rmsd, saturated,
                 output ready);
endinterface

@@ rtl/quaternion_rotate_scale_rmsd.sv @@
// Rotates each target point by the matrix of the configured quaternion, scales it, and
// reports the length of its error against the reference point; the point that closes a
// set (last_point, or the 1024th point) also reports sqrt(sum/count) and clears the set.
// One transaction is in flight at a time: the block takes no new point until the result
// of the last one is taken. Each point runs through the single shared 35x33 multiplier,
// which computes its 25 products in turn, then the integer square root that resolves one
// result bit per cycle; a closing point also runs the restoring divider for the set mean
// and a second square root. The block takes the next point in the cycle after its result
// is taken.
`include "assert_macros.svh"

module quaternion_rotate_scale_rmsd (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [qrsr_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [qrsr_pkg::CSR_DATA_W-1:0]        csr_wdata,
   qrsr_req_if.sink                               req_ch,
   qrsr_rsp_if.source                             rsp_ch
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_QMUL  = 12'b0000_0000_0010,
      S_MAT   = 12'b0000_0000_0100,
      S_RMUL  = 12'b0000_0000_1000,
      S_SCALE = 12'b0000_0001_0000,
      S_ERR   = 12'b0000_0010_0000,
      S_SQ    = 12'b0000_0100_0000,
      S_SUM   = 12'b0000_1000_0000,
      S_ROOT  = 12'b0001_0000_0000,
      S_DIV   = 12'b0010_0000_0000,
      S_MROOT = 12'b0100_0000_0000,
      S_OUT   = 12'b1000_0000_0000
   } state_type;

   // quaternion product slots
   localparam logic [3:0] QP_WW = 4'd0;
   localparam logic [3:0] QP_XX = 4'd1;
   localparam logic [3:0] QP_YY = 4'd2;
   localparam logic [3:0] QP_ZZ = 4'd3;
   localparam logic [3:0] QP_XY = 4'd4;
   localparam logic [3:0] QP_WZ = 4'd5;
   localparam logic [3:0] QP_XZ = 4'd6;
   localparam logic [3:0] QP_WY = 4'd7;
   localparam logic [3:0] QP_YZ = 4'd8;
   localparam logic [3:0] QP_WX = 4'd9;

   localparam logic signed [qrsr_pkg::ERR_W-1:0] E_MAX = qrsr_pkg::ERR_W'(64'sh7FFF_FFFF);
   localparam logic signed [qrsr_pkg::ERR_W-1:0] E_MIN = -qrsr_pkg::ERR_W'(64'sh8000_0000);

   state_type state_ff, state_in;

   // configuration registers
   logic signed [qrsr_pkg::QUAT_W-1:0]  qw_ff, qx_ff, qy_ff, qz_ff;
   logic [qrsr_pkg::SCALE_W-1:0]        scale_ff;

   // sequencing
   logic [qrsr_pkg::STEP_W-1:0]         step_ff;
   logic [1:0]                          row_ff, col_ff;
   logic                                phase_ff;

   // latched transaction
   logic signed [qrsr_pkg::COORD_W-1:0] ref_ff [3];
   logic signed [qrsr_pkg::COORD_W-1:0] tgt_ff [3];
   logic                                last_ff;

   // datapath
   logic signed [qrsr_pkg::MUL_A_W-1:0] mul_a;
   logic signed [qrsr_pkg::MUL_B_W-1:0] mul_b;
   logic signed [qrsr_pkg::MUL_P_W-1:0] mul_p, prod_ff;
   logic signed [qrsr_pkg::QPROD_W-1:0] qp_ff [qrsr_pkg::NUM_QPROD];
   logic signed [qrsr_pkg::RM_W-1:0]    rm_ff [3][3];
   logic signed [qrsr_pkg::RM_W-1:0]    rm_in [3][3];
   logic signed [qrsr_pkg::ACC_W-1:0]   acc_ff [3];
   logic signed [qrsr_pkg::SC_W-1:0]    sc_ff [3];
   logic signed [qrsr_pkg::ERR_OUT_W-1:0] err_ff [3];
   logic signed [qrsr_pkg::ERR_OUT_W-1:0] err_in [3];
   logic [2:0]                          lane_sat;
   logic                                csat_ff;
   logic [qrsr_pkg::SUM_W-1:0]          sq_ff;
   logic signed [qrsr_pkg::ROT_W-1:0]   rot_sel;
   logic signed [qrsr_pkg::SCL_P_W-1:0] scl_round;

   // set accumulators
   logic [qrsr_pkg::SUM_W-1:0]          sum_ff;
   logic [qrsr_pkg::CNT_W-1:0]          cnt_ff;
   logic                                ovf_ff;
   logic [qrsr_pkg::SUM_W:0]            sum_add;
   logic [qrsr_pkg::SUM_W-1:0]          sum_in;
   logic                                ovf_in;
   logic                                done_in;

   // result registers
   logic [qrsr_pkg::CNT_W-1:0]          idx_ff;
   logic                                done_ff;
   logic                                sat_ff;
   logic [qrsr_pkg::ERR_OUT_W-1:0]      perr_ff;
   logic [qrsr_pkg::ERR_OUT_W-1:0]      rmsd_ff;

   // square root unit
   logic [qrsr_pkg::SUM_W-1:0]          sqv_ff;
   logic [qrsr_pkg::REM_W-1:0]          sqr_ff, sqr_in;
   logic [qrsr_pkg::ROOT_W-1:0]         sqo_ff, sqo_in;
   logic [qrsr_pkg::REM_W+1:0]          sq_sh, sq_trial;
   logic                                sq_ge;

   // divider
   logic [qrsr_pkg::SUM_W-1:0]          dvq_ff, dvq_in;
   logic [qrsr_pkg::CNT_W:0]            dvr_ff, dvr_in, dv_d;
   logic [qrsr_pkg::CNT_W+1:0]          dv_sh;
   logic                                dv_ge;

   logic                                last_mul;

   // shared multiplier operand select
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      rot_sel = acc_ff[row_ff][qrsr_pkg::ACC_W-1:qrsr_pkg::ROT_SHIFT];
      case (state_ff)
         S_QMUL: begin
            case (step_ff[3:0])
               QP_WW: begin mul_a = qrsr_pkg::MUL_A_W'(qw_ff); mul_b = qrsr_pkg::MUL_B_W'(qw_ff); end
               QP_XX: begin mul_a = qrsr_pkg::MUL_A_W'(qx_ff); mul_b = qrsr_pkg::MUL_B_W'(qx_ff); end
               QP_YY: begin mul_a = qrsr_pkg::MUL_A_W'(qy_ff); mul_b = qrsr_pkg::MUL_B_W'(qy_ff); end
               QP_ZZ: begin mul_a = qrsr_pkg::MUL_A_W'(qz_ff); mul_b = qrsr_pkg::MUL_B_W'(qz_ff); end
               QP_XY: begin mul_a = qrsr_pkg::MUL_A_W'(qx_ff); mul_b = qrsr_pkg::MUL_B_W'(qy_ff); end
               QP_WZ: begin mul_a = qrsr_pkg::MUL_A_W'(qw_ff); mul_b = qrsr_pkg::MUL_B_W'(qz_ff); end
               QP_XZ: begin mul_a = qrsr_pkg::MUL_A_W'(qx_ff); mul_b = qrsr_pkg::MUL_B_W'(qz_ff); end
               QP_WY: begin mul_a = qrsr_pkg::MUL_A_W'(qw_ff); mul_b = qrsr_pkg::MUL_B_W'(qy_ff); end
               QP_YZ: begin mul_a = qrsr_pkg::MUL_A_W'(qy_ff); mul_b = qrsr_pkg::MUL_B_W'(qz_ff); end
               QP_WX: begin mul_a = qrsr_pkg::MUL_A_W'(qw_ff); mul_b = qrsr_pkg::MUL_B_W'(qx_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         S_RMUL: begin
            mul_a = qrsr_pkg::MUL_A_W'(rm_ff[row_ff][col_ff]);
            mul_b = qrsr_pkg::MUL_B_W'(tgt_ff[col_ff]);
         end
         S_SCALE: begin
            mul_a = qrsr_pkg::MUL_A_W'(rot_sel);
            mul_b = qrsr_pkg::MUL_B_W'(signed'({1'b0, scale_ff}));
         end
         S_SQ: begin
            mul_a = qrsr_pkg::MUL_A_W'(err_ff[row_ff]);
            mul_b = qrsr_pkg::MUL_B_W'(err_ff[row_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // rounding of the scaled coordinate
   assign scl_round = qrsr_pkg::SCL_P_W'(prod_ff) +
                      qrsr_pkg::SCL_P_W'(1 << (qrsr_pkg::SCL_SHIFT - 1));

   // rotation matrix from quaternion products
   function automatic logic signed [qrsr_pkg::RM_W-1:0] qx34(
      input logic signed [qrsr_pkg::QPROD_W-1:0] v);
      return qrsr_pkg::RM_W'(v);
   endfunction

   always_comb begin
      rm_in[0][0] = qx34(qp_ff[QP_WW]) + qx34(qp_ff[QP_XX]) - qx34(qp_ff[QP_YY])
                    - qx34(qp_ff[QP_ZZ]);
      rm_in[1][1] = qx34(qp_ff[QP_WW]) - qx34(qp_ff[QP_XX]) + qx34(qp_ff[QP_YY])
                    - qx34(qp_ff[QP_ZZ]);
      rm_in[2][2] = qx34(qp_ff[QP_WW]) - qx34(qp_ff[QP_XX]) - qx34(qp_ff[QP_YY])
                    + qx34(qp_ff[QP_ZZ]);
      rm_in[0][1] = (qx34(qp_ff[QP_XY]) - qx34(qp_ff[QP_WZ])) <<< 1;
      rm_in[0][2] = (qx34(qp_ff[QP_XZ]) + qx34(qp_ff[QP_WY])) <<< 1;
      rm_in[1][0] = (qx34(qp_ff[QP_XY]) + qx34(qp_ff[QP_WZ])) <<< 1;
      rm_in[1][2] = (qx34(qp_ff[QP_YZ]) - qx34(qp_ff[QP_WX])) <<< 1;
      rm_in[2][0] = (qx34(qp_ff[QP_XZ]) - qx34(qp_ff[QP_WY])) <<< 1;
      rm_in[2][1] = (qx34(qp_ff[QP_YZ]) + qx34(qp_ff[QP_WX])) <<< 1;
   end

   // error components with saturation to 32 bits
   always_comb begin
      logic signed [qrsr_pkg::ERR_W-1:0] e;
      for (int i = 0; i < 3; i++) begin
         e = qrsr_pkg::ERR_W'(ref_ff[i]) - qrsr_pkg::ERR_W'(sc_ff[i]);
         lane_sat[i] = 1'b0;
         err_in[i]   = qrsr_pkg::ERR_OUT_W'(e);
         if (e > E_MAX) begin
            err_in[i]   = qrsr_pkg::ERR_OUT_W'(E_MAX);
            lane_sat[i] = 1'b1;
         end else if (e < E_MIN) begin
            err_in[i]   = qrsr_pkg::ERR_OUT_W'(E_MIN);
            lane_sat[i] = 1'b1;
         end
      end
   end

   // saturating set sum and set close
   always_comb begin
      sum_add = {1'b0, sum_ff} + {1'b0, sq_ff};
      sum_in  = sum_add[qrsr_pkg::SUM_W] ? '1 : sum_add[qrsr_pkg::SUM_W-1:0];
      ovf_in  = ovf_ff | sum_add[qrsr_pkg::SUM_W];
      done_in = last_ff || (cnt_ff == qrsr_pkg::CNT_W'(qrsr_pkg::MAX_POINTS - 1));
   end

   // one step of the integer square root
   always_comb begin
      sq_sh    = {sqr_ff, sqv_ff[qrsr_pkg::SUM_W-1 -: 2]};
      sq_trial = {2'b00, sqo_ff, 2'b01};
      sq_ge    = sq_sh >= sq_trial;
      sqr_in   = sq_ge ? qrsr_pkg::REM_W'(sq_sh - sq_trial) : qrsr_pkg::REM_W'(sq_sh);
      sqo_in   = {sqo_ff[qrsr_pkg::ROOT_W-2:0], sq_ge};
   end

   // one step of the restoring divider
   always_comb begin
      dv_d   = {1'b0, idx_ff} + (qrsr_pkg::CNT_W+1)'(1);
      dv_sh  = {dvr_ff, dvq_ff[qrsr_pkg::SUM_W-1]};
      dv_ge  = dv_sh >= {1'b0, dv_d};
      dvr_in = dv_ge ? (qrsr_pkg::CNT_W+1)'(dv_sh - {1'b0, dv_d})
                     : (qrsr_pkg::CNT_W+1)'(dv_sh);
      dvq_in = {dvq_ff[qrsr_pkg::SUM_W-2:0], dv_ge};
   end

   // end of a multiply pass
   always_comb begin
      case (state_ff)
         S_QMUL:  last_mul = step_ff == qrsr_pkg::STEP_W'(qrsr_pkg::NUM_QPROD - 1);
         S_RMUL:  last_mul = (row_ff == 2'd2) && (col_ff == 2'd2);
         S_SCALE: last_mul = row_ff == 2'd2;
         S_SQ:    last_mul = row_ff == 2'd2;
         default: last_mul = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_ch.valid) state_in = S_QMUL;
         S_QMUL:  if (phase_ff && last_mul) state_in = S_MAT;
         S_MAT:   state_in = S_RMUL;
         S_RMUL:  if (phase_ff && last_mul) state_in = S_SCALE;
         S_SCALE: if (phase_ff && last_mul) state_in = S_ERR;
         S_ERR:   state_in = S_SQ;
         S_SQ:    if (phase_ff && last_mul) state_in = S_SUM;
         S_SUM:   state_in = S_ROOT;
         S_ROOT: begin
            if (step_ff == qrsr_pkg::STEP_W'(qrsr_pkg::SQRT_STEPS - 1))
               state_in = done_ff ? S_DIV : S_OUT;
         end
         S_DIV: begin
            if (step_ff == qrsr_pkg::STEP_W'(qrsr_pkg::DIV_STEPS - 1)) state_in = S_MROOT;
         end
         S_MROOT: begin
            if (step_ff == qrsr_pkg::STEP_W'(qrsr_pkg::SQRT_STEPS - 1)) state_in = S_OUT;
         end
         S_OUT:   if (rsp_ch.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control, configuration and set state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         phase_ff <= 1'b0;
         qw_ff    <= qrsr_pkg::QUAT_W'(32767);
         qx_ff    <= '0;
         qy_ff    <= '0;
         qz_ff    <= '0;
         scale_ff <= qrsr_pkg::SCALE_W'(65536);
         sum_ff   <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         // register writes
         if (csr_we) begin
            case (csr_addr)
               qrsr_pkg::CSR_QUAT_W: qw_ff    <= csr_wdata[qrsr_pkg::QUAT_W-1:0];
               qrsr_pkg::CSR_QUAT_X: qx_ff    <= csr_wdata[qrsr_pkg::QUAT_W-1:0];
               qrsr_pkg::CSR_QUAT_Y: qy_ff    <= csr_wdata[qrsr_pkg::QUAT_W-1:0];
               qrsr_pkg::CSR_QUAT_Z: qz_ff    <= csr_wdata[qrsr_pkg::QUAT_W-1:0];
               qrsr_pkg::CSR_SCALE:  scale_ff <= csr_wdata[qrsr_pkg::SCALE_W-1:0];
               default: ;
            endcase
         end

         // step counters
         if (state_in != state_ff) begin
            step_ff  <= '0;
            row_ff   <= '0;
            col_ff   <= '0;
            phase_ff <= 1'b0;
         end else begin
            case (state_ff)
               S_QMUL: begin
                  phase_ff <= ~phase_ff;
                  if (phase_ff) step_ff <= step_ff + 1'b1;
               end
               S_RMUL: begin
                  phase_ff <= ~phase_ff;
                  if (phase_ff) begin
                     if (col_ff == 2'd2) begin
                        col_ff <= '0;
                        row_ff <= row_ff + 1'b1;
                     end else begin
                        col_ff <= col_ff + 1'b1;
                     end
                  end
               end
               S_SCALE, S_SQ: begin
                  phase_ff <= ~phase_ff;
                  if (phase_ff) row_ff <= row_ff + 1'b1;
               end
               S_ROOT, S_DIV, S_MROOT: step_ff <= step_ff + 1'b1;
               default: ;
            endcase
         end

         // set accumulators
         if (state_ff == S_SUM) begin
            if (done_in) begin
               sum_ff <= '0;
               cnt_ff <= '0;
               ovf_ff <= 1'b0;
            end else begin
               sum_ff <= sum_in;
               cnt_ff <= cnt_ff + 1'b1;
               ovf_ff <= ovf_in;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;

      // latch the transaction
      if (req_ch.valid && req_ch.ready) begin
         ref_ff[0] <= req_ch.ref_x;
         ref_ff[1] <= req_ch.ref_y;
         ref_ff[2] <= req_ch.ref_z;
         tgt_ff[0] <= req_ch.tgt_x;
         tgt_ff[1] <= req_ch.tgt_y;
         tgt_ff[2] <= req_ch.tgt_z;
         last_ff   <= req_ch.last_point;
      end

      if (state_ff == S_QMUL && phase_ff)
         qp_ff[step_ff[3:0]] <= prod_ff[qrsr_pkg::QPROD_W-1:0];

      // matrix, and rounding bias for the rotated sums
      if (state_ff == S_MAT) begin
         rm_ff <= rm_in;
         for (int i = 0; i < 3; i++)
            acc_ff[i] <= qrsr_pkg::ACC_W'(1 << (qrsr_pkg::ROT_SHIFT - 1));
      end

      if (state_ff == S_RMUL && phase_ff)
         acc_ff[row_ff] <= acc_ff[row_ff] + qrsr_pkg::ACC_W'(prod_ff);

      if (state_ff == S_SCALE && phase_ff)
         sc_ff[row_ff] <= scl_round[qrsr_pkg::SCL_P_W-1:qrsr_pkg::SCL_SHIFT];

      if (state_ff == S_ERR) begin
         err_ff  <= err_in;
         csat_ff <= |lane_sat;
         sq_ff   <= '0;
      end

      if (state_ff == S_SQ && phase_ff)
         sq_ff <= sq_ff + prod_ff[qrsr_pkg::SUM_W-1:0];

      // close out the point, start the root of its squared error
      if (state_ff == S_SUM) begin
         idx_ff  <= cnt_ff;
         done_ff <= done_in;
         sat_ff  <= csat_ff | ovf_in;
         dvq_ff  <= sum_in;
         dvr_ff  <= '0;
         sqv_ff  <= sq_ff;
         sqr_ff  <= '0;
         sqo_ff  <= '0;
         rmsd_ff <= '0;
      end

      if (state_ff == S_ROOT || state_ff == S_MROOT) begin
         sqv_ff <= sqv_ff << 2;
         sqr_ff <= sqr_in;
         sqo_ff <= sqo_in;
      end

      if (state_ff == S_ROOT && step_ff == qrsr_pkg::STEP_W'(qrsr_pkg::SQRT_STEPS - 1))
         perr_ff <= sqo_in;

      if (state_ff == S_MROOT && step_ff == qrsr_pkg::STEP_W'(qrsr_pkg::SQRT_STEPS - 1))
         rmsd_ff <= sqo_in;

      // mean of the set, then reload the root unit
      if (state_ff == S_DIV) begin
         dvq_ff <= dvq_in;
         dvr_ff <= dvr_in;
         if (step_ff == qrsr_pkg::STEP_W'(qrsr_pkg::DIV_STEPS - 1)) begin
            sqv_ff <= dvq_in;
            sqr_ff <= '0;
            sqo_ff <= '0;
         end
      end
   end

   // channel outputs
   assign req_ch.ready       = state_ff == S_IDLE;
   assign rsp_ch.valid       = state_ff == S_OUT;
   assign rsp_ch.point_error = perr_ff;
   assign rsp_ch.point_index = qrsr_pkg::PIDX_W'(idx_ff);
   assign rsp_ch.set_done    = done_ff;
   assign rsp_ch.set_rmsd    = rmsd_ff;
   assign rsp_ch.saturated   = sat_ff;

   // checks
   `ASSERT_IMPLY(a_one_in_flight, clock, reset, req_ch.ready, !rsp_ch.valid)
   `ASSERT_NEXT(a_accept_starts, clock, reset, req_ch.valid && req_ch.ready,
                state_ff == S_QMUL && step_ff == '0 && !phase_ff)
   `ASSERT_IMPLY(a_rmsd_only_on_close, clock, reset, rsp_ch.valid && !rsp_ch.set_done,
                 rsp_ch.set_rmsd == '0)
   `ASSERT_NEXT(a_set_cleared, clock, reset,
                rsp_ch.valid && rsp_ch.ready && rsp_ch.set_done,
                cnt_ff == '0 && sum_ff == '0 && !ovf_ff)

endmodule

@@ tb/sv/qrsr_checker.sv @@
// predicts the result of every accepted point pair and compares it with the result channel
module qrsr_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [qrsr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [qrsr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   qrsr_req_if                              req_ch,
   qrsr_rsp_if                              rsp_ch,
   output int                               fail_count,
   output int                               results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [qrsr_pkg::ERR_OUT_W-1:0] point_error;
      logic [qrsr_pkg::PIDX_W-1:0]    point_index;
      logic                           set_done;
      logic [qrsr_pkg::ERR_OUT_W-1:0] set_rmsd;
      logic                           saturated;
   } point_result_type;

   // shadow copy of the configuration
   logic signed [qrsr_pkg::QUAT_W-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
   logic [qrsr_pkg::SCALE_W-1:0]       scale_q;

   // running set state
   logic [63:0]   err_sum;
   int unsigned   set_count;
   logic          sum_sat;

   point_result_type expected_results[$];

   // floor integer square root
   function automatic logic [31:0] floor_root(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = '0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[31:0];
   endfunction

   // rotate, scale and measure one pair, then update the set state
   function automatic point_result_type rotate_and_measure();
      point_result_type res;
      longint signed w, x, y, z, scl;
      longint signed rm[3][3];
      longint signed r[3], t[3];
      longint signed acc, rot, scaled, e;
      logic [63:0] mag, sq;
      logic comp_sat, done;
      w = longint'(quat_w_q); x = longint'(quat_x_q);
      y = longint'(quat_y_q); z = longint'(quat_z_q);
      scl = longint'({40'd0, scale_q});
      r[0] = longint'(req_ch.ref_x); r[1] = longint'(req_ch.ref_y);
      r[2] = longint'(req_ch.ref_z);
      t[0] = longint'(req_ch.tgt_x); t[1] = longint'(req_ch.tgt_y);
      t[2] = longint'(req_ch.tgt_z);
      rm[0][0] = w*w + x*x - y*y - z*z;
      rm[0][1] = 2 * (x*y - w*z);
      rm[0][2] = 2 * (x*z + w*y);
      rm[1][0] = 2 * (x*y + w*z);
      rm[1][1] = w*w - x*x + y*y - z*z;
      rm[1][2] = 2 * (y*z - w*x);
      rm[2][0] = 2 * (x*z - w*y);
      rm[2][1] = 2 * (y*z + w*x);
      rm[2][2] = w*w - x*x - y*y + z*z;
      sq = '0;
      comp_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = rm[i][0]*t[0] + rm[i][1]*t[1] + rm[i][2]*t[2];
         rot = (acc + (64'sd1 <<< 29)) >>> 30;
         scaled = (rot * scl + (64'sd1 <<< 15)) >>> 16;
         e = r[i] - scaled;
         if (e > 64'sd2147483647) begin
            e = 64'sd2147483647;
            comp_sat = 1'b1;
         end
         if (e < -64'sd2147483648) begin
            e = -64'sd2147483648;
            comp_sat = 1'b1;
         end
         mag = (e < 0) ? -e : e;
         sq = sq + mag * mag;
      end
      // saturating set sum
      if (err_sum > (~64'd0) - sq) begin
         err_sum = ~64'd0;
         sum_sat = 1'b1;
      end else begin
         err_sum = err_sum + sq;
      end
      done = req_ch.last_point || (set_count >= qrsr_pkg::MAX_POINTS - 1);
      res.point_error = floor_root(sq);
      res.point_index = set_count[qrsr_pkg::PIDX_W-1:0];
      res.set_done = done;
      res.saturated = comp_sat || sum_sat;
      if (done) begin
         res.set_rmsd = floor_root(err_sum / (64'(set_count) + 64'd1));
         err_sum = '0;
         set_count = 0;
         sum_sat = 1'b0;
      end else begin
         res.set_rmsd = '0;
         set_count = set_count + 1;
      end
      return res;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      point_result_type exp_r;
      if (reset) begin
         quat_w_q = 16'sd32767;
         quat_x_q = '0;
         quat_y_q = '0;
         quat_z_q = '0;
         scale_q = 24'd65536;
         err_sum = '0;
         set_count = 0;
         sum_sat = 1'b0;
         expected_results.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (qrsr_pkg::csr_index_type'(csr_addr))
               qrsr_pkg::CSR_QUAT_W: quat_w_q = csr_wdata[qrsr_pkg::QUAT_W-1:0];
               qrsr_pkg::CSR_QUAT_X: quat_x_q = csr_wdata[qrsr_pkg::QUAT_W-1:0];
               qrsr_pkg::CSR_QUAT_Y: quat_y_q = csr_wdata[qrsr_pkg::QUAT_W-1:0];
               qrsr_pkg::CSR_QUAT_Z: quat_z_q = csr_wdata[qrsr_pkg::QUAT_W-1:0];
               qrsr_pkg::CSR_SCALE:  scale_q = csr_wdata;
               default: ;
            endcase
         end
         // accepted request transaction
         if (req_ch.valid && req_ch.ready) expected_results.push_back(rotate_and_measure());
         // accepted response transaction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual error %0d",
                        $time, rsp_ch.point_error);
               fail_count++;
            end else begin
               exp_r = expected_results.pop_front();
               check_field("point_error", 64'(exp_r.point_error), 64'(rsp_ch.point_error));
               check_field("point_index", 64'(exp_r.point_index), 64'(rsp_ch.point_index));
               check_field("set_done", 64'(exp_r.set_done), 64'(rsp_ch.set_done));
               check_field("set_rmsd", 64'(exp_r.set_rmsd), 64'(rsp_ch.set_rmsd));
               check_field("saturated", 64'(exp_r.saturated), 64'(rsp_ch.saturated));
            end
         end
      end
      results_pending = expected_results.size();
   end

   initial fail_count = 0;

endmodule

@@ tb/sv/tb_quaternion_rotate_scale_rmsd.sv @@
module tb_quaternion_rotate_scale_rmsd;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_START = 4000;
   localparam int HOLD_LEN = 600;

   logic clock;
   logic reset;
   logic csr_we;
   logic [qrsr_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [qrsr_pkg::CSR_DATA_W-1:0] csr_wdata;
   int fail_count;
   int results_pending;
   int cycle_count;
   int burst_left;

   qrsr_req_if req_ch();
   qrsr_rsp_if rsp_ch();

   quaternion_rotate_scale_rmsd u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   qrsr_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: changing stall pattern plus one long hold-off
   always @(posedge clock) begin
      int rcv_cycle;
      int rcv_mode;
      if (reset) begin
         rcv_cycle = 0;
         rcv_mode = 0;
         rsp_ch.ready <= 1'b0;
      end else begin
         rcv_cycle++;
         if (rcv_cycle % 256 == 0) rcv_mode = $urandom_range(0, 2);
         if (rcv_cycle >= HOLD_START && rcv_cycle < HOLD_START + HOLD_LEN)
            rsp_ch.ready <= 1'b0;
         else if (rcv_mode == 0)
            rsp_ch.ready <= 1'b1;
         else if (rcv_mode == 1)
            rsp_ch.ready <= 1'($urandom_range(0, 1));
         else
            rsp_ch.ready <= ($urandom_range(0, 6) == 0);
      end
   end

   // register write, one per cycle; the caller drops the write enable
   task automatic write_reg(qrsr_pkg::csr_index_type idx,
                            logic [qrsr_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // wait for an idle block, then load a full configuration
   task automatic load_config(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                              logic [15:0] z, logic [23:0] s);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(qrsr_pkg::CSR_QUAT_W, {8'd0, w});
      write_reg(qrsr_pkg::CSR_QUAT_X, {8'd0, x});
      write_reg(qrsr_pkg::CSR_QUAT_Y, {8'd0, y});
      write_reg(qrsr_pkg::CSR_QUAT_Z, {8'd0, z});
      write_reg(qrsr_pkg::CSR_SCALE, s);
      csr_we <= 1'b0;
   endtask

   // offer one pair and wait for its transaction; bursts separated by gaps
   task automatic send_pair(logic [23:0] rx, logic [23:0] ry, logic [23:0] rz,
                            logic [23:0] tx, logic [23:0] ty, logic [23:0] tz,
                            logic last);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.ref_x <= rx;
      req_ch.ref_y <= ry;
      req_ch.ref_z <= rz;
      req_ch.tgt_x <= tx;
      req_ch.tgt_y <= ty;
      req_ch.tgt_z <= tz;
      req_ch.last_point <= last;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0, 1:    return 24'($urandom());
         2:       return ($urandom_range(0, 1)) ? 24'h7fffff : 24'h800000;
         default: return 24'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic send_random(logic last);
      send_pair(rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), last);
   endtask

   // sets of random length with random content
   task automatic run_sets(int n_items);
      int set_len;
      int k;
      k = 0;
      while (k < n_items) begin
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
         for (int i = 0; i < set_len && k < n_items; i++) begin
            send_random(i == set_len - 1 || k == n_items - 1);
            k++;
         end
      end
   endtask

   task automatic load_random_config();
      load_config(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  24'($urandom()));
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      cycle_count = 0;
      burst_left = 1;
      req_ch.valid = 1'b0;
      req_ch.ref_x = '0;
      req_ch.ref_y = '0;
      req_ch.ref_z = '0;
      req_ch.tgt_x = '0;
      req_ch.tgt_y = '0;
      req_ch.tgt_z = '0;
      req_ch.last_point = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pairs under the reset configuration
      send_pair('0, '0, '0, '0, '0, '0, 1'b1);
      send_pair(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 24'h800000, 1'b0);
      send_pair(24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0);
      send_pair(24'h001000, '0, '0, 24'h001000, '0, '0, 1'b1);
      send_pair(24'hffffff, 24'h000001, 24'h800000, 24'h7fffff, 24'hffffff, 24'h000001, 1'b1);

      // non-unit quaternion at its extremes with the largest scale: saturation
      load_config(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 24'hffffff);
      send_pair('0, '0, '0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0);
      send_pair(24'h800000, 24'h7fffff, '0, 24'h800000, 24'h800000, 24'h800000, 1'b0);
      send_pair(24'h7fffff, '0, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 1'b0);
      send_pair('0, '0, '0, 24'h7fffff, 24'h800000, 24'h800000, 1'b1);
      send_pair('0, '0, '0, 24'h000010, 24'h000020, 24'h000030, 1'b1);

      // zero quaternion and zero scale
      load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000);
      send_pair(24'h7fffff, 24'h800000, 24'h7fffff, 24'h123456, 24'h654321, 24'h7fffff, 1'b0);
      send_pair(24'h800000, 24'h800000, 24'h800000, '0, '0, '0, 1'b1);

      // random sets under several settings
      load_random_config();
      run_sets(350);
      load_config(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 24'hffffff);
      run_sets(200);
      load_config(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 24'h000000);
      run_sets(100);

      // one overlong set that closes on the point limit, then normal sets
      load_config(16'h5a82, 16'h0000, 16'h5a82, 16'h0000, 24'h010000);
      for (int i = 0; i < 1100; i++) send_random(1'b0);
      send_random(1'b1);
      load_random_config();
      run_sets(190);

      // drain
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
